// File: rtl/core/coc_pkg.sv
// Shared types, constants and the CORDIC step for circle_obstacle_clearance.
// Used by coc_cordic, coc_rotate, coc_square and the top level.
// No dependencies.
package coc_pkg;

    // sine / cosine format: Q1.30 in a 32-bit word
    localparam int TRIG_W    = 32;
    localparam int TRIG_FRAC = 30;
    localparam logic signed [TRIG_W-1:0] CORDIC_START = 32'sd652032874;
    localparam logic signed [TRIG_W-1:0] ROUND_HALF   = 32'sd536870912;

    localparam int CORDIC_ITERS    = 20;
    localparam int ITERS_PER_STAGE = 2;
    localparam int CORDIC_STAGES   = CORDIC_ITERS / ITERS_PER_STAGE;
    localparam int ROT_STAGES      = 3;
    localparam int SQ_STAGES       = 4;

    // arctangent of 2^-i, quarter turn = 2^30
    localparam logic signed [TRIG_W-1:0] ATAN_TBL [CORDIC_ITERS] = '{
        32'sd536870912, 32'sd316933405, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10680862,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304
    };

    localparam int ANGLE_FULL_W = 16;
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam int MARGIN_W    = 64;
    localparam int MARGIN_FRAC = 16;
    localparam int SAT_W       = 66;
    localparam logic signed [MARGIN_W-1:0] MARGIN_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [MARGIN_W-1:0] MARGIN_MIN = 64'sh8000_0000_0000_0000;

    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_OBST_X   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_OBST_Y   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_OBST_RAD = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BODY_X   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BODY_Y   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_VEH_RAD  = 3'd5;
    localparam logic [31:0] RADIUS_ONE = 32'h0001_0000;

    typedef struct packed {
        logic signed [TRIG_W-1:0] x;
        logic signed [TRIG_W-1:0] y;
        logic signed [TRIG_W-1:0] z;
    } cordic_vec_t;

    // one rotation-mode micro-rotation
    function automatic cordic_vec_t cordic_iter(input cordic_vec_t v, input logic [4:0] i);
        cordic_vec_t r;
        logic signed [TRIG_W-1:0] xs;
        logic signed [TRIG_W-1:0] ys;
        xs = v.x >>> i;
        ys = v.y >>> i;
        if (!v.z[TRIG_W-1]) begin
            r.x = v.x - ys;
            r.y = v.y + xs;
            r.z = v.z - ATAN_TBL[i];
        end else begin
            r.x = v.x + ys;
            r.y = v.y - xs;
            r.z = v.z + ATAN_TBL[i];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/circle_obstacle_clearance.sv
// Pipeline from an accepted request to its result: 10 CORDIC stages,
// 3 rotate/translate stages, 4 square/sum stages, the last being the output.
// Throughput: one pose per cycle; a stage holds its item only while every later
// stage is full and the output is stalled, so bubbles close up under back-pressure.
// Reset (aresetn low, synchronous) empties the pipeline and loads register
// defaults: obstacle and offsets zero, both radii one metre.
module circle_obstacle_clearance #(
    parameter int COORD_BITS = 32,
    parameter int ANGLE_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // pos_x, pos_y, heading (low to high), zero padded to bytes
    input  logic [((2*COORD_BITS+ANGLE_BITS+7)/8)*8-1:0] s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // margin
    output logic [coc_pkg::MARGIN_W-1:0]         m_tdata,
    // violated
    output logic [0:0]                           m_tuser,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [coc_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [COORD_BITS-1:0]                cfg_data
);
    import coc_pkg::*;

    localparam int CW   = COORD_BITS;
    localparam int AB   = ANGLE_BITS;
    localparam int CS   = CORDIC_STAGES;
    localparam int NSTG = CORDIC_STAGES + ROT_STAGES + SQ_STAGES;

    logic signed [CW-1:0] obst_x_reg, obst_y_reg, body_x_reg, body_y_reg;
    logic [CW-2:0]        obst_r_reg, veh_r_reg;

    logic [NSTG-1:0] v_reg, v_next, en;

    logic signed [TRIG_W-1:0]   cos_w, sin_w;
    logic [2*CW-1:0]            pose_w;
    logic signed [CW+2:0]       dx_w, dy_w;
    logic signed [MARGIN_W-1:0] margin_w;
    logic                       violated_w;

    // configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            obst_x_reg <= '0;
            obst_y_reg <= '0;
            obst_r_reg <= (CW-1)'(RADIUS_ONE);
            body_x_reg <= '0;
            body_y_reg <= '0;
            veh_r_reg  <= (CW-1)'(RADIUS_ONE);
        end else if (cfg_valid) begin
            case (cfg_addr)
                REG_OBST_X:   obst_x_reg <= $signed(cfg_data);
                REG_OBST_Y:   obst_y_reg <= $signed(cfg_data);
                REG_OBST_RAD: obst_r_reg <= cfg_data[CW-2:0];
                REG_BODY_X:   body_x_reg <= $signed(cfg_data);
                REG_BODY_Y:   body_y_reg <= $signed(cfg_data);
                REG_VEH_RAD:  veh_r_reg  <= cfg_data[CW-2:0];
                default: ;
            endcase
        end
    end

    // a stage may load when it or any later stage has a bubble, or output drains
    always_comb begin
        for (int i = 0; i < NSTG; i++) begin
            en[i] = m_tready || ((v_reg | NSTG'((64'd1 << i) - 64'd1)) != {NSTG{1'b1}});
        end
        v_next[0] = en[0] ? s_tvalid : v_reg[0];
        for (int i = 1; i < NSTG; i++) begin
            v_next[i] = en[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[NSTG-1];

    coc_cordic #(
        .PW (2*CW),
        .AB (AB)
    ) u_cordic (
        .aclk    (aclk),
        .en      (en[CS-1:0]),
        .heading (s_tdata[2*CW+AB-1:2*CW]),
        .pay_in  (s_tdata[2*CW-1:0]),
        .cos_out (cos_w),
        .sin_out (sin_w),
        .pay_out (pose_w)
    );

    coc_rotate #(
        .CW (CW)
    ) u_rotate (
        .aclk   (aclk),
        .en     (en[CS+ROT_STAGES-1:CS]),
        .cos_in (cos_w),
        .sin_in (sin_w),
        .pos_x  ($signed(pose_w[CW-1:0])),
        .pos_y  ($signed(pose_w[2*CW-1:CW])),
        .body_x (body_x_reg),
        .body_y (body_y_reg),
        .obst_x (obst_x_reg),
        .obst_y (obst_y_reg),
        .dx     (dx_w),
        .dy     (dy_w)
    );

    coc_square #(
        .CW (CW)
    ) u_square (
        .aclk         (aclk),
        .en           (en[NSTG-1:CS+ROT_STAGES]),
        .dx_in        (dx_w),
        .dy_in        (dy_w),
        .obst_r       (obst_r_reg),
        .veh_r        (veh_r_reg),
        .margin_out   (margin_w),
        .violated_out (violated_w)
    );

    assign m_tdata = margin_w;
    assign m_tuser = violated_w;

`ifndef NO_ASSERTIONS
    a_flag_matches_margin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] == (!m_tdata[MARGIN_W-1] && (m_tdata != '0))))
        else $error("violated flag disagrees with margin sign");

    a_empty_out_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output stage is empty");

    a_drain_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |-> s_tready)
        else $error("input stalled while result drains");

    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

    a_rise_needs_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(en[NSTG-1] && v_reg[NSTG-2]))
        else $error("output valid without a request moving in");
`endif

endmodule

// File: rtl/core/coc_cordic.sv
// Pipelined CORDIC sine/cosine, two micro-rotations per stage, quadrant fold
// in the last stage. Carries the pose alongside. Depends on coc_pkg.
module coc_cordic #(
    parameter int PW = 64,
    parameter int AB = 16
) (
    input  logic                                 aclk,
    input  logic [coc_pkg::CORDIC_STAGES-1:0]    en,
    input  logic [AB-1:0]                        heading,
    input  logic [PW-1:0]                        pay_in,
    output logic signed [coc_pkg::TRIG_W-1:0]    cos_out,
    output logic signed [coc_pkg::TRIG_W-1:0]    sin_out,
    output logic [PW-1:0]                        pay_out
);
    import coc_pkg::*;

    localparam int NS = CORDIC_STAGES;

    cordic_vec_t              vec_reg  [NS-1];
    logic [1:0]               quad_reg [NS-1];
    logic [PW-1:0]            pay_reg  [NS];
    logic signed [TRIG_W-1:0] cos_reg, sin_reg;
    logic signed [TRIG_W-1:0] cos_next, sin_next;
    cordic_vec_t              vout [NS];
    cordic_vec_t              v0;
    logic [ANGLE_FULL_W-1:0]  ang_full;

    assign ang_full = ANGLE_FULL_W'(heading) << (ANGLE_FULL_W - AB);

    always_comb begin
        v0.x = CORDIC_START;
        v0.y = '0;
        // residual angle within the quadrant
        v0.z = {2'b00, ang_full[ANGLE_FULL_W-3:0], 16'h0000};
        vout[0] = cordic_iter(cordic_iter(v0, 5'd0), 5'd1);
        for (int s = 1; s < NS; s++) begin
            vout[s] = cordic_iter(cordic_iter(vec_reg[s-1], 5'(ITERS_PER_STAGE * s)),
                                  5'(ITERS_PER_STAGE * s + 1));
        end
    end

    always_comb begin
        case (quad_reg[NS-2])
            QUAD_0: begin
                cos_next = vout[NS-1].x;
                sin_next = vout[NS-1].y;
            end
            QUAD_1: begin
                cos_next = -vout[NS-1].y;
                sin_next = vout[NS-1].x;
            end
            QUAD_2: begin
                cos_next = -vout[NS-1].x;
                sin_next = -vout[NS-1].y;
            end
            default: begin
                cos_next = vout[NS-1].y;
                sin_next = -vout[NS-1].x;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            vec_reg[0]  <= vout[0];
            quad_reg[0] <= ang_full[ANGLE_FULL_W-1:ANGLE_FULL_W-2];
            pay_reg[0]  <= pay_in;
        end
        for (int s = 1; s < NS - 1; s++) begin
            if (en[s]) begin
                vec_reg[s]  <= vout[s];
                quad_reg[s] <= quad_reg[s-1];
                pay_reg[s]  <= pay_reg[s-1];
            end
        end
        if (en[NS-1]) begin
            cos_reg         <= cos_next;
            sin_reg         <= sin_next;
            pay_reg[NS-1]   <= pay_reg[NS-2];
        end
    end

    assign cos_out = cos_reg;
    assign sin_out = sin_reg;
    assign pay_out = pay_reg[NS-1];

endmodule

// File: rtl/core/coc_rotate.sv
// Rotates the body offset by the heading, rounds to Q16.16 and forms the
// distance to the obstacle centre; three stages. Depends on coc_pkg.
module coc_rotate #(
    parameter int CW = 32
) (
    input  logic                              aclk,
    input  logic [coc_pkg::ROT_STAGES-1:0]    en,
    input  logic signed [coc_pkg::TRIG_W-1:0] cos_in,
    input  logic signed [coc_pkg::TRIG_W-1:0] sin_in,
    input  logic signed [CW-1:0]              pos_x,
    input  logic signed [CW-1:0]              pos_y,
    input  logic signed [CW-1:0]              body_x,
    input  logic signed [CW-1:0]              body_y,
    input  logic signed [CW-1:0]              obst_x,
    input  logic signed [CW-1:0]              obst_y,
    output logic signed [CW+2:0]              dx,
    output logic signed [CW+2:0]              dy
);
    import coc_pkg::*;

    localparam int PWID = CW + TRIG_W;
    localparam int SW   = PWID + 2;
    localparam int DW   = CW + 3;

    logic signed [PWID-1:0] bc_reg, bs_reg, sc_reg, ss_reg;
    logic signed [CW-1:0]   px1_reg, py1_reg, px2_reg, py2_reg;
    logic signed [SW-1:0]   sum_x, sum_y;
    logic signed [DW-1:0]   rx_next, ry_next, rx_reg, ry_reg;
    logic signed [DW-1:0]   dx_next, dy_next, dx_reg, dy_reg;

    // x' = bx*cos - by*sin, y' = bx*sin + by*cos, rounded half up
    always_comb begin
        sum_x   = SW'(bc_reg) - SW'(ss_reg) + SW'(ROUND_HALF);
        sum_y   = SW'(bs_reg) + SW'(sc_reg) + SW'(ROUND_HALF);
        rx_next = DW'(sum_x >>> TRIG_FRAC);
        ry_next = DW'(sum_y >>> TRIG_FRAC);
        dx_next = DW'(px2_reg) + rx_reg - DW'(obst_x);
        dy_next = DW'(py2_reg) + ry_reg - DW'(obst_y);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            bc_reg  <= PWID'(body_x) * PWID'(cos_in);
            bs_reg  <= PWID'(body_x) * PWID'(sin_in);
            sc_reg  <= PWID'(body_y) * PWID'(cos_in);
            ss_reg  <= PWID'(body_y) * PWID'(sin_in);
            px1_reg <= pos_x;
            py1_reg <= pos_y;
        end
        if (en[1]) begin
            rx_reg  <= rx_next;
            ry_reg  <= ry_next;
            px2_reg <= px1_reg;
            py2_reg <= py1_reg;
        end
        if (en[2]) begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
    end

    assign dx = dx_reg;
    assign dy = dy_reg;

endmodule

// File: rtl/core/coc_square.sv
// Squares safe radius, dx, dy via split half-width products; radius^2 minus
// dx^2, dy^2 floored to Q48.16 with clamp; four stages. Depends on coc_pkg.
module coc_square #(
    parameter int CW = 32
) (
    input  logic                                aclk,
    input  logic [coc_pkg::SQ_STAGES-1:0]       en,
    input  logic signed [CW+2:0]                dx_in,
    input  logic signed [CW+2:0]                dy_in,
    input  logic [CW-2:0]                       obst_r,
    input  logic [CW-2:0]                       veh_r,
    output logic signed [coc_pkg::MARGIN_W-1:0] margin_out,
    output logic                                violated_out
);
    import coc_pkg::*;

    localparam int DW = CW + 3;
    localparam int MW = CW + 2;
    localparam int HW = (MW + 1) / 2;
    localparam int GW = MW - HW;
    localparam int QW = 2 * MW;
    localparam int TW = QW + 2;
    localparam int FW = TW - MARGIN_FRAC;

    // term 0: safe radius, 1: dx, 2: dy
    logic [MW-1:0]   mag_next [3];
    logic [MW-1:0]   mag_reg  [3];
    logic [2*GW-1:0] hh_reg   [3];
    logic [MW-1:0]   hl_reg   [3];
    logic [2*HW-1:0] ll_reg   [3];
    logic [QW-1:0]   sq_next  [3];
    logic [QW-1:0]   sq_reg   [3];

    logic signed [TW-1:0]       total;
    logic signed [FW-1:0]       floored;
    logic signed [SAT_W-1:0]    wide;
    logic signed [MARGIN_W-1:0] margin_next, margin_reg;
    logic                       violated_next, violated_reg;

    always_comb begin
        mag_next[0] = MW'(obst_r) + MW'(veh_r);
        mag_next[1] = dx_in[DW-1] ? MW'(-dx_in) : MW'(dx_in);
        mag_next[2] = dy_in[DW-1] ? MW'(-dy_in) : MW'(dy_in);
        for (int k = 0; k < 3; k++) begin
            sq_next[k] = (QW'(hh_reg[k]) << (2 * HW)) + (QW'(hl_reg[k]) << (HW + 1))
                       + QW'(ll_reg[k]);
        end
        total   = $signed(TW'(sq_reg[0])) - $signed(TW'(sq_reg[1]))
                - $signed(TW'(sq_reg[2]));
        floored = FW'(total >>> MARGIN_FRAC);
        wide    = SAT_W'(floored);
        if (wide > SAT_W'(MARGIN_MAX)) begin
            margin_next = MARGIN_MAX;
        end else if (wide < SAT_W'(MARGIN_MIN)) begin
            margin_next = MARGIN_MIN;
        end else begin
            margin_next = MARGIN_W'(wide);
        end
        violated_next = !margin_next[MARGIN_W-1] && (margin_next != '0);
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            if (en[0]) begin
                mag_reg[k] <= mag_next[k];
            end
            if (en[1]) begin
                hh_reg[k] <= (2*GW)'(mag_reg[k][MW-1:HW]) * (2*GW)'(mag_reg[k][MW-1:HW]);
                hl_reg[k] <= MW'(mag_reg[k][MW-1:HW]) * MW'(mag_reg[k][HW-1:0]);
                ll_reg[k] <= (2*HW)'(mag_reg[k][HW-1:0]) * (2*HW)'(mag_reg[k][HW-1:0]);
            end
            if (en[2]) begin
                sq_reg[k] <= sq_next[k];
            end
        end
        if (en[3]) begin
            margin_reg   <= margin_next;
            violated_reg <= violated_next;
        end
    end

    assign margin_out   = margin_reg;
    assign violated_out = violated_reg;

endmodule
